@@ rtl/mpsd_pkg.sv @@
// shared types and constants of the motor pwm slew and deadband driver
// no dependencies; every other file of the block refers to it by scoped names

package mpsd_pkg;

    // fixed width of the signed motor command
    localparam int CMD_WIDTH = 16;

    // configuration register index
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_DUTY    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_MOVING  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLEW_STEP   = 2'd2;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_SLEW,
        ST_OUT
    } drv_state_t;

    // status of a bit-serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

@@ rtl/mpsd_ifs.sv @@
// valid/ready channel interfaces of the motor pwm driver
// depends on mpsd_pkg for the command and register index widths

interface mpsd_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  mode;
    logic signed [mpsd_pkg::CMD_WIDTH-1:0] command;

    modport source (output valid, mode, command, input ready);
    modport sink   (input valid, mode, command, output ready);
endinterface

interface mpsd_res_if #(parameter int DUTY_WIDTH = 8);
    logic                         valid;
    logic                         ready;
    logic [DUTY_WIDTH-1:0]        duty;
    logic                         forward_enable;
    logic                         backward_enable;
    logic signed [DUTY_WIDTH:0]   applied_pwm;

    modport source (output valid, duty, forward_enable, backward_enable, applied_pwm,
                    input ready);
    modport sink   (input valid, duty, forward_enable, backward_enable, applied_pwm,
                    output ready);
endinterface

interface mpsd_cfg_if #(parameter int DUTY_WIDTH = 8);
    logic                                  valid;
    logic                                  ready;
    logic [mpsd_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [DUTY_WIDTH-1:0]                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mpsd_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on mpsd_pkg for the unit status struct

module mpsd_mul #(
    parameter int W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [W-1:0]           a,
    input  logic [W-1:0]           b,
    output logic [2*W-1:0]         product,
    output mpsd_pkg::unit_status_t status
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2*W-1:0]   acc_reg, acc_next;
    logic [2*W-1:0]   a_sh_reg, a_sh_next;
    logic [W-1:0]     b_sh_reg, b_sh_next;

    // control: count W steps after start
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath: add shifted multiplicand when the low multiplier bit is set
    always_comb
    begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        if (start)
        begin
            acc_next  = '0;
            a_sh_next = (2*W)'(a);
            b_sh_next = b;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_next = acc_reg + a_sh_reg;
            end
            a_sh_next = a_sh_reg << 1;
            b_sh_next = b_sh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/mpsd_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on mpsd_pkg; needs numerator below divisor shifted up by W bits

module mpsd_div #(
    parameter int W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2*W-1:0]         num,
    input  logic [W-1:0]           den,
    output logic [W-1:0]           quotient,
    output mpsd_pkg::unit_status_t status
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     low_reg, low_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W:0]       partial;
    logic [W+1:0]     diff;

    // control: count W quotient bits after start
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // trial subtract of the divisor from the shifted remainder
    assign partial = {rem_reg, low_reg[W-1]};
    assign diff    = {1'b0, partial} - {2'b00, den_reg};

    // datapath: quotient bits shift into the low half
    always_comb
    begin
        rem_next = rem_reg;
        low_next = low_reg;
        den_next = den_reg;
        if (start)
        begin
            rem_next = num[2*W-1:W];
            low_next = num[W-1:0];
            den_next = den;
        end
        else if (busy_reg)
        begin
            if (!diff[W+1])
            begin
                rem_next = diff[W-1:0];
                low_next = {low_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = partial[W-1:0];
                low_next = {low_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign quotient    = low_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/motor_pwm_slew_deadband_driver.sv @@
// top level of the motor pwm driver: registers, sequencer, slew limiter, output stage
// depends on mpsd_pkg, mpsd_ifs, mpsd_mul and mpsd_div
//
//  channel | dir | payload                                          | handshake
//  cmd     | in  | mode, command                                    | valid/ready
//  res     | out | duty, forward_enable, backward_enable, applied_pwm| valid/ready
//  cfg     | in  | index, data                                      | valid/ready
//
// one word at a time: a ramped word with a nonzero command and max_duty above one passes
// through PREP, MUL, DIV, SLEW and OUT, waiting on the serial multiplier and divider;
// other ramped words pass through PREP, SLEW and OUT and raw words through PREP and OUT;
// the next word is taken from IDLE, in the cycle after the result is loaded.
// reset loads max_duty all ones, min_moving_duty and slew_step zero, applied duty zero.
// a result waits in the output register; the next word is taken meanwhile and stalls
// only at its output step. cfg is always ready.

module motor_pwm_slew_deadband_driver #(
    parameter int DUTY_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    mpsd_cmd_if.sink   cmd,
    mpsd_res_if.source res,
    mpsd_cfg_if.sink   cfg
);

    localparam int W  = DUTY_WIDTH;
    localparam int CW = mpsd_pkg::CMD_WIDTH;

    mpsd_pkg::drv_state_t state_reg, state_next;

    logic [W-1:0]        max_duty_reg, max_duty_next;
    logic [W-1:0]        min_moving_reg, min_moving_next;
    logic [W-1:0]        slew_step_reg, slew_step_next;
    logic signed [W:0]   present_reg, present_next;
    logic signed [W:0]   target_reg, target_next;
    logic [W-1:0]        lo_reg, lo_next;
    logic                mode_reg, mode_next;
    logic [CW-1:0]       cmd_reg, cmd_next;
    logic                out_valid_reg, out_valid_next;
    logic [W-1:0]        duty_reg, duty_next;
    logic                fwd_reg, fwd_next;
    logic                bwd_reg, bwd_next;
    logic signed [W:0]   applied_reg, applied_next;

    logic                cmd_neg;
    logic [CW-1:0]       cmd_mag;
    logic [W-1:0]        xc;
    logic [W-1:0]        lo;
    logic [W:0]          xc_signed;
    logic [W-1:0]        mapped;
    logic [W:0]          mapped_signed;
    logic [W:0]          max_signed;

    logic                mul_start;
    logic [2*W-1:0]      product;
    logic [W-1:0]        quotient;
    logic                div_start;
    mpsd_pkg::unit_status_t mul_stat;
    mpsd_pkg::unit_status_t div_stat;

    logic signed [W+1:0] p2, t2, s2, up, dn;
    logic [W:0]          abs_p;
    logic                out_free;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        max_duty_next   = max_duty_reg;
        min_moving_next = min_moving_reg;
        slew_step_next  = slew_step_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mpsd_pkg::REG_MAX_DUTY:   max_duty_next   = cfg.data;
                mpsd_pkg::REG_MIN_MOVING: min_moving_next = cfg.data;
                mpsd_pkg::REG_SLEW_STEP:  slew_step_next  = cfg.data;
                default:                  ;
            endcase
        end
    end

    // command magnitude, clamp to max and deadband floor
    assign cmd_neg   = cmd_reg[CW-1];
    assign cmd_mag   = cmd_neg ? (~cmd_reg + 1'b1) : cmd_reg;
    assign xc        = (cmd_mag > CW'(max_duty_reg)) ? max_duty_reg : cmd_mag[W-1:0];
    assign lo        = (min_moving_reg > max_duty_reg) ? max_duty_reg : min_moving_reg;
    assign xc_signed = cmd_neg ? (~{1'b0, xc} + 1'b1) : {1'b0, xc};
    assign max_signed = cmd_neg ? (~{1'b0, max_duty_reg} + 1'b1) : {1'b0, max_duty_reg};

    // mapped value after the divide, with the command sign
    assign mapped        = quotient + lo_reg;
    assign mapped_signed = cmd_neg ? (~{1'b0, mapped} + 1'b1) : {1'b0, mapped};

    // slew limiter arithmetic
    assign p2 = {present_reg[W], present_reg};
    assign t2 = {target_reg[W], target_reg};
    assign s2 = {2'b00, slew_step_reg};
    assign up = p2 + s2;
    assign dn = p2 - s2;

    // output magnitude of the applied duty
    assign abs_p    = present_reg[W] ? (~present_reg + 1'b1) : present_reg;
    assign out_free = !out_valid_reg || res.ready;

    mpsd_mul #(.W(W)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (xc - 1'b1),
        .b       (max_duty_reg - lo),
        .product (product),
        .status  (mul_stat)
    );

    mpsd_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (product),
        .den      (max_duty_reg - 1'b1),
        .quotient (quotient),
        .status   (div_stat)
    );

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        fwd_next       = fwd_reg;
        bwd_next       = bwd_reg;
        applied_next   = applied_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        cmd.ready      = (state_reg == mpsd_pkg::ST_IDLE);

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mpsd_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = cmd.mode;
                    cmd_next   = cmd.command;
                    state_next = mpsd_pkg::ST_PREP;
                end
            end
            mpsd_pkg::ST_PREP:
            begin
                lo_next = lo;
                if (mode_reg)
                begin
                    present_next = xc_signed;
                    state_next   = mpsd_pkg::ST_OUT;
                end
                else if (cmd_reg == '0 || max_duty_reg == '0)
                begin
                    target_next = '0;
                    state_next  = mpsd_pkg::ST_SLEW;
                end
                else if (max_duty_reg == W'(1))
                begin
                    target_next = max_signed;
                    state_next  = mpsd_pkg::ST_SLEW;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = mpsd_pkg::ST_MUL;
                end
            end
            mpsd_pkg::ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    state_next = mpsd_pkg::ST_DIV;
                end
            end
            mpsd_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    target_next = mapped_signed;
                    state_next  = mpsd_pkg::ST_SLEW;
                end
            end
            mpsd_pkg::ST_SLEW:
            begin
                if (target_reg == '0 || slew_step_reg == '0)
                begin
                    present_next = target_reg;
                end
                else if (t2 > p2)
                begin
                    present_next = (up < t2) ? up[W:0] : target_reg;
                end
                else if (t2 < p2)
                begin
                    present_next = (dn > t2) ? dn[W:0] : target_reg;
                end
                state_next = mpsd_pkg::ST_OUT;
            end
            mpsd_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    duty_next      = (abs_p > {1'b0, max_duty_reg}) ? max_duty_reg
                                                                    : abs_p[W-1:0];
                    fwd_next       = !present_reg[W] && (present_reg != '0);
                    bwd_next       = present_reg[W];
                    applied_next   = present_reg;
                    out_valid_next = 1'b1;
                    state_next     = mpsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsd_pkg::ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpsd_pkg::ST_IDLE;
            max_duty_reg   <= '1;
            min_moving_reg <= '0;
            slew_step_reg  <= '0;
            present_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_duty_reg   <= max_duty_next;
            min_moving_reg <= min_moving_next;
            slew_step_reg  <= slew_step_next;
            present_reg    <= present_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        target_reg  <= target_next;
        lo_reg      <= lo_next;
        mode_reg    <= mode_next;
        cmd_reg     <= cmd_next;
        duty_reg    <= duty_next;
        fwd_reg     <= fwd_next;
        bwd_reg     <= bwd_next;
        applied_reg <= applied_next;
    end

    assign res.valid           = out_valid_reg;
    assign res.duty            = duty_reg;
    assign res.forward_enable  = fwd_reg;
    assign res.backward_enable = bwd_reg;
    assign res.applied_pwm     = applied_reg;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of motor_pwm_slew_deadband_driver: directed and random commands
// depends on rtl/mpsd_pkg.sv, rtl/mpsd_ifs.sv and the driver rtl; it predicts every result

module tb;

    localparam int DUTY_WIDTH  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 40;

    // command modes
    localparam logic MODE_RAMPED = 1'b0;
    localparam logic MODE_RAW    = 1'b1;

    // register index past the last defined one, writes to it are dropped
    localparam logic [mpsd_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    // receiver stall styles
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    typedef struct {
        logic [DUTY_WIDTH-1:0] duty;
        logic                  forward_enable;
        logic                  backward_enable;
        logic signed [DUTY_WIDTH:0] applied_pwm;
    } bridge_drive_t;

    logic clk;
    logic rst_n;

    mpsd_cmd_if                               cmd_ch ();
    mpsd_res_if #(.DUTY_WIDTH(DUTY_WIDTH))    res_ch ();
    mpsd_cfg_if #(.DUTY_WIDTH(DUTY_WIDTH))    cfg_ch ();

    motor_pwm_slew_deadband_driver #(
        .DUTY_WIDTH(DUTY_WIDTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predictor copy of the registers and the applied duty
    int max_duty_reg   = 255;
    int min_moving_reg = 0;
    int slew_step_reg  = 0;
    int drive_level    = 0;

    bridge_drive_t pending_drive_q[$];
    bridge_drive_t want_word;
    int            mismatch_count = 0;
    int            cycle_count    = 0;

    // sender burst state
    int burst_left = 0;
    int last_command = 0;

    // receiver state
    rx_style_t rx_style   = RX_ALWAYS;
    int        style_left = 0;
    int        hold_cycles = 0;
    int        rx_phase   = 0;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // deadband mapping of a nonzero command onto min_moving..max
    function automatic int deadband_map(input int command);
        int m;
        int lo;
        int mag;
        int x;
        int mapped;
        m  = max_duty_reg;
        lo = min_moving_reg;
        if (command == 0 || m == 0)
            return 0;
        if (lo > m)
            lo = m;
        mag = (command < 0) ? -command : command;
        x   = (mag > m) ? m : mag;
        if (m == 1)
            mapped = m;
        else
            mapped = (x - 1) * (m - lo) / (m - 1) + lo;
        return (command < 0) ? -mapped : mapped;
    endfunction

    // advance the applied duty by one command and form the bridge drive word
    function automatic bridge_drive_t next_bridge_drive(input logic mode, input int command);
        bridge_drive_t word;
        int            target;
        int            mag;
        int            stepped;
        if (mode == MODE_RAW) begin
            mag = (command < 0) ? -command : command;
            if (mag > max_duty_reg)
                mag = max_duty_reg;
            drive_level = (command < 0) ? -mag : mag;
        end
        else begin
            target = deadband_map(command);
            if (target == 0 || slew_step_reg == 0) begin
                drive_level = target;
            end
            else if (target > drive_level) begin
                stepped     = drive_level + slew_step_reg;
                drive_level = (stepped < target) ? stepped : target;
            end
            else if (target < drive_level) begin
                stepped     = drive_level - slew_step_reg;
                drive_level = (stepped > target) ? stepped : target;
            end
        end
        mag = (drive_level < 0) ? -drive_level : drive_level;
        if (mag > max_duty_reg)
            mag = max_duty_reg;
        word.duty            = mag[DUTY_WIDTH-1:0];
        word.forward_enable  = (drive_level > 0);
        word.backward_enable = (drive_level < 0);
        word.applied_pwm     = drive_level[DUTY_WIDTH:0];
        return word;
    endfunction

    // predict on accepted commands, track register writes, check results
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    mpsd_pkg::REG_MAX_DUTY:   max_duty_reg   = int'(cfg_ch.data);
                    mpsd_pkg::REG_MIN_MOVING: min_moving_reg = int'(cfg_ch.data);
                    mpsd_pkg::REG_SLEW_STEP:  slew_step_reg  = int'(cfg_ch.data);
                    default: ;
                endcase
            end
            if (cmd_ch.valid && cmd_ch.ready)
                pending_drive_q.push_back(next_bridge_drive(cmd_ch.mode, int'(cmd_ch.command)));
            if (res_ch.valid && res_ch.ready) begin
                if (pending_drive_q.size() == 0) begin
                    $error("result with no pending command: applied_pwm %0d",
                           res_ch.applied_pwm);
                    mismatch_count++;
                end
                else begin
                    want_word = pending_drive_q.pop_front();
                    if (res_ch.duty !== want_word.duty) begin
                        $error("duty: expected %0d, actual %0d", want_word.duty, res_ch.duty);
                        mismatch_count++;
                    end
                    if (res_ch.forward_enable !== want_word.forward_enable) begin
                        $error("forward_enable: expected %0b, actual %0b",
                               want_word.forward_enable, res_ch.forward_enable);
                        mismatch_count++;
                    end
                    if (res_ch.backward_enable !== want_word.backward_enable) begin
                        $error("backward_enable: expected %0b, actual %0b",
                               want_word.backward_enable, res_ch.backward_enable);
                        mismatch_count++;
                    end
                    if (res_ch.applied_pwm !== want_word.applied_pwm) begin
                        $error("applied_pwm: expected %0d, actual %0d",
                               want_word.applied_pwm, res_ch.applied_pwm);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall style
    always @(negedge clk) begin
        rx_phase++;
        if (hold_cycles > 0) begin
            hold_cycles--;
            res_ch.ready = 1'b0;
        end
        else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(3));
                style_left = $urandom_range(50, 300);
            end
            style_left--;
            case (rx_style)
                RX_ALWAYS:   res_ch.ready = 1'b1;
                RX_COIN:     res_ch.ready = 1'($urandom_range(1));
                RX_SPARSE:   res_ch.ready = ($urandom_range(3) == 0);
                default:     res_ch.ready = ((rx_phase % 7) < 4);
            endcase
        end
    end

    // offer one command word, with bursts and random gaps in between
    task automatic offer_command(input logic mode, input int command);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                cmd_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        cmd_ch.valid   = 1'b1;
        cmd_ch.mode    = mode;
        cmd_ch.command = command[mpsd_pkg::CMD_WIDTH-1:0];
        last_command   = command;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // stop offering and wait until every pending result has come back
    task automatic wait_all_results();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        burst_left   = 0;
        while (pending_drive_q.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input logic [mpsd_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  input int data);
        wait_all_results();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data[DUTY_WIDTH-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(input int max_duty, input int min_moving, input int slew_step);
        write_register(mpsd_pkg::REG_MAX_DUTY, max_duty);
        write_register(mpsd_pkg::REG_MIN_MOVING, min_moving);
        write_register(mpsd_pkg::REG_SLEW_STEP, slew_step);
    endtask

    // random command: zero, 16-bit, near the duty range, -300..300 or repeats to settle ramps
    function automatic int pick_command();
        logic [15:0] bits;
        int          pick;
        int          reach;
        pick  = $urandom_range(99);
        bits  = 16'($urandom);
        reach = max_duty_reg + 20;
        if (pick < 10)
            return 0;
        else if (pick < 30)
            return int'($signed(bits));
        else if (pick < 45)
            return last_command;
        else if (pick < 75)
            return $urandom_range(2 * reach) - reach;
        else
            return $urandom_range(600) - 300;
    endfunction

    // reset values, extremes of the command and the most negative command
    task automatic test_reset_defaults();
        offer_command(MODE_RAMPED, 0);
        offer_command(MODE_RAMPED, 1);
        offer_command(MODE_RAMPED, 255);
        offer_command(MODE_RAMPED, 32767);
        offer_command(MODE_RAMPED, -32767);
        offer_command(MODE_RAMPED, -32768);
        offer_command(MODE_RAW, 300);
        offer_command(MODE_RAW, -5);
    endtask

    // deadband mapping with no ramping
    task automatic test_deadband_map();
        write_all(200, 40, 0);
        offer_command(MODE_RAMPED, 1);
        offer_command(MODE_RAMPED, 2);
        offer_command(MODE_RAMPED, 100);
        offer_command(MODE_RAMPED, 199);
        offer_command(MODE_RAMPED, 200);
        offer_command(MODE_RAMPED, -1000);
        offer_command(MODE_RAMPED, -150);
    endtask

    // slew limiting, zero snap and raw bypass
    task automatic test_slew_ramp();
        write_register(mpsd_pkg::REG_SLEW_STEP, 30);
        offer_command(MODE_RAMPED, 200);
        offer_command(MODE_RAMPED, 200);
        offer_command(MODE_RAMPED, 200);
        offer_command(MODE_RAMPED, -200);
        offer_command(MODE_RAMPED, -200);
        offer_command(MODE_RAMPED, 0);
        offer_command(MODE_RAW, 90);
        offer_command(MODE_RAMPED, 150);
    endtask

    // max of one, min_moving above max, largest step
    task automatic test_max_of_one();
        write_all(1, 255, 255);
        offer_command(MODE_RAMPED, 5);
        offer_command(MODE_RAMPED, -5);
        offer_command(MODE_RAMPED, 0);
        offer_command(MODE_RAW, 3);
    endtask

    // max lowered while driving, then a write to the unused index
    task automatic test_max_lowered();
        write_all(255, 0, 10);
        offer_command(MODE_RAW, 250);
        write_register(mpsd_pkg::REG_MAX_DUTY, 50);
        offer_command(MODE_RAMPED, 40);
        offer_command(MODE_RAMPED, 40);
        write_register(REG_UNUSED, 'hA5);
        offer_command(MODE_RAMPED, -1);
    endtask

    // receiver holds off while commands keep coming, then the sender drains
    task automatic test_backpressure();
        int n;
        write_all(180, 25, 7);
        @(negedge clk);
        hold_cycles = 400;
        for (n = 0; n < 16; n++)
            offer_command(1'($urandom_range(1)), pick_command());
        wait_all_results();
        for (n = 0; n < 16; n++)
            offer_command(1'($urandom_range(1)), pick_command());
        wait_all_results();
    endtask

    // random commands over several register settings
    task automatic test_random_phases();
        int phase;
        int n;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_all(255, 0, 0);
                1: write_all(1, 255, 255);
                2: write_all(255, 255, 1);
                3: write_all($urandom_range(2, 40), $urandom_range(255), $urandom_range(1, 10));
                4: write_all(128, 60, 255);
                5: write_all($urandom_range(7, 60), 0, 3);
                default: write_all($urandom_range(1, 255), $urandom_range(255),
                                   $urandom_range(255));
            endcase
            for (n = 0; n < 200; n++)
                offer_command(($urandom_range(3) == 0) ? MODE_RAW : MODE_RAMPED,
                              pick_command());
        end
    endtask

    // sequence of tests
    initial begin
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.mode    = MODE_RAMPED;
        cmd_ch.command = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = mpsd_pkg::REG_MAX_DUTY;
        cfg_ch.data    = '0;
        res_ch.ready   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_deadband_map();
        test_slew_ramp();
        test_max_of_one();
        test_max_lowered();
        test_backpressure();
        test_random_phases();

        wait_all_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0 && pending_drive_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
